/* src/mma_pkg.sv */
package mma_pkg;

  localparam int CH_IN_BITS    = 3;
  localparam int AVG_BITS      = 24;
  localparam int FILL_OUT_BITS = 5;
  localparam int FRAC_BITS     = 8;

endpackage

/* src/mma_if.sv */
interface mma_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  import mma_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CH_IN_BITS-1:0]         channel;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface mma_result_if;
  import mma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [AVG_BITS-1:0] average;
  logic [FILL_OUT_BITS-1:0]   filled;

  modport source (output valid, output average, output filled, input ready);
  modport sink (input valid, input average, input filled, output ready);
endinterface

/* src/mma_ram.sv */
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/multichannel_moving_average.sv */
// Each input transaction steps through ST_STATE_RD, ST_WIN_RD, ST_UPDATE, ST_PREP,
//   ST_DIV and ST_DONE to a valid result; SUM_BITS = SAMPLE_BITS + clog2(WINDOW).
// A new sample is taken only in ST_IDLE, once the last result has been loaded into
//   the output. The bit-serial restoring divider retires one quotient bit per cycle.
// Reset clears the sequencer, the output valid and the per-channel valid bits;
//   sample and channel-state memories need no clearing pass.
module multichannel_moving_average #(
  parameter int WINDOW      = 16,
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  mma_sample_if.sink   samples,
  mma_result_if.source results
);
  import mma_pkg::*;

  localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_BITS  = $clog2(WINDOW);
  localparam int FW        = $clog2(WINDOW + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int ST_W      = POS_BITS + FW + SUM_BITS;
  localparam int SLOT_BITS = $clog2(CHANNELS * WINDOW);
  localparam int DVD       = SUM_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(DVD);
  localparam int RES_BITS  = (DVD + 1 > AVG_BITS) ? DVD + 1 : AVG_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STATE_RD,
    ST_WIN_RD,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                       state;
  logic [CHANNELS-1:0]          ch_valid;
  logic [CH_BITS-1:0]           ch;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [POS_BITS-1:0]          pos;
  logic [FW-1:0]                fill;
  logic signed [SUM_BITS-1:0]   sum;
  logic                         neg;
  logic [DVD-1:0]               quo;
  logic [FW-1:0]                rem;
  logic [CNT_BITS-1:0]          cnt;

  logic [ST_W-1:0]              st_rdata;
  logic [ST_W-1:0]              st_cur;
  logic [ST_W-1:0]              st_wdata;
  logic                         st_we;
  logic [SAMPLE_BITS-1:0]       win_rdata;
  logic                         win_we;
  logic [SLOT_BITS-1:0]         win_raddr;
  logic [SLOT_BITS-1:0]         win_waddr;

  logic                         full;
  logic signed [SUM_BITS-1:0]   old_ext;
  logic signed [SUM_BITS-1:0]   sum_next;
  logic [POS_BITS-1:0]          pos_next;
  logic [FW-1:0]                fill_next;
  logic [SUM_BITS-1:0]          mag;
  logic [FW:0]                  trial;
  logic [FW:0]                  diff;
  logic                         qbit;
  logic [RES_BITS-1:0]          q_ext;
  logic [RES_BITS-1:0]          res;
  logic                         in_range;
  logic                         out_load;

  assign samples.ready = (state == ST_IDLE);
  assign in_range      = 32'(samples.channel) < CHANNELS;

  assign st_cur    = ch_valid[ch] ? st_rdata : '0;
  assign win_raddr = SLOT_BITS'(ch * WINDOW) + SLOT_BITS'(st_cur[ST_W-1 -: POS_BITS]);
  assign win_waddr = SLOT_BITS'(ch * WINDOW) + SLOT_BITS'(pos);

  always_comb begin
    full      = (fill == FW'(WINDOW));
    old_ext   = full ? SUM_BITS'($signed(win_rdata)) : '0;
    sum_next  = sum - old_ext + SUM_BITS'(smp);
    pos_next  = (pos == POS_BITS'(WINDOW - 1)) ? '0 : pos + 1'b1;
    fill_next = full ? fill : fill + 1'b1;
    st_we     = (state == ST_UPDATE);
    win_we    = (state == ST_UPDATE);
    st_wdata  = {pos_next, fill_next, sum_next};
    mag       = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    trial     = {rem, quo[DVD-1]};
    diff      = trial - {1'b0, fill};
    qbit      = (trial >= {1'b0, fill});
    q_ext     = RES_BITS'(quo);
    res       = neg ? -q_ext : q_ext;
    out_load  = (state == ST_DONE) && (!results.valid || results.ready);
  end

  mma_ram #(
    .WIDTH(ST_W),
    .DEPTH(CHANNELS)
  ) u_state_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(ch),
    .wdata(st_wdata),
    .raddr(ch),
    .rdata(st_rdata)
  );

  mma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(CHANNELS * WINDOW)
  ) u_window_ram (
    .clk  (clk),
    .we   (win_we),
    .waddr(win_waddr),
    .wdata(smp),
    .raddr(win_raddr),
    .rdata(win_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ch_valid        <= '0;
      results.valid   <= 1'b0;
    end else begin
      if (out_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (samples.valid && in_range) begin
            ch    <= CH_BITS'(samples.channel);
            smp   <= samples.sample;
            state <= ST_STATE_RD;
          end
        end
        ST_STATE_RD: begin
          state <= ST_WIN_RD;
        end
        ST_WIN_RD: begin
          pos   <= st_cur[ST_W-1 -: POS_BITS];
          fill  <= st_cur[SUM_BITS +: FW];
          sum   <= st_cur[SUM_BITS-1:0];
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          ch_valid[ch] <= 1'b1;
          sum          <= sum_next;
          fill         <= fill_next;
          state        <= ST_PREP;
        end
        ST_PREP: begin
          neg   <= sum[SUM_BITS-1];
          quo   <= {mag, FRAC_BITS'(0)};
          rem   <= '0;
          cnt   <= CNT_BITS'(DVD - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= qbit ? diff[FW-1:0] : trial[FW-1:0];
          quo <= {quo[DVD-2:0], qbit};
          if (cnt == '0) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            results.average <= res[AVG_BITS-1:0];
            results.filled  <= FILL_OUT_BITS'(fill);
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> fill >= FW'(1) && fill <= FW'(WINDOW))
    else $error("fill count out of range during divide");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < fill)
    else $error("divider remainder not below divisor");

  a_drop_out_of_range: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && !in_range |=> state == ST_IDLE)
    else $error("out-of-range channel started a transaction");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && results.valid && !results.ready |=> state == ST_DONE)
    else $error("result overwritten while output stalled");

  a_valid_bit_set: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |=> ch_valid[ch])
    else $error("channel state not marked valid after update");

endmodule
